FILE: rtl/core/pcv_pkg.sv
`default_nettype none

package pcv_pkg;

  localparam int LABEL_W         = 6;
  localparam int LABEL_SLOTS     = 1 << LABEL_W;
  localparam int FRAC_W          = 16;
  localparam int CONF_W          = FRAC_W + 1;
  localparam int DIV_CNT_W       = $clog2(CONF_W);
  localparam int CLASS_SLOTS_DEF = 64;
  localparam int MAX_VOTES_DEF   = 1024;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [2:0] {
    BACK_IDLE,
    BACK_UPDATE,
    BACK_PREP,
    BACK_DIVIDE,
    BACK_COMMIT
  } pcv_back_state_e;

endpackage

`default_nettype wire

FILE: rtl/core/pcv_in_if.sv
`default_nettype none

interface pcv_in_if import pcv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] neuron_class;
  logic [LABEL_W-1:0] expected_class;
  logic               last_neuron;

  modport source (output valid, neuron_class, expected_class, last_neuron, input ready);
  modport sink   (input valid, neuron_class, expected_class, last_neuron, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pcv_out_if.sv
`default_nettype none

interface pcv_out_if import pcv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] voted_class;
  logic [CONF_W-1:0]  confidence;

  modport source (output valid, voted_class, confidence, input ready);
  modport sink   (input valid, voted_class, confidence, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pcv_front.sv
`default_nettype none

module pcv_front import pcv_pkg::*; #(
  parameter int MAX_VOTES = MAX_VOTES_DEF,
  parameter int VW        = $clog2(MAX_VOTES + 1),
  parameter int PW        = (MAX_VOTES > 1) ? $clog2(MAX_VOTES) : 1,
  parameter int EW        = 2 * LABEL_W + 2 + PW + VW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  pcv_in_if.sink             in_i,
  output logic               push_o,
  output logic [EW-1:0]      data_o,
  input  wire logic          full_i
);

  logic [VW-1:0] cnt_q, cnt_d;
  logic          counted;
  logic [VW-1:0] votes;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Votes past the limit are still queued so that a last mark closes the sample.
  assign counted = (cnt_q < VW'(MAX_VOTES));
  assign votes   = counted ? VW'(cnt_q + 1'b1) : cnt_q;

  assign data_o = {in_i.neuron_class, in_i.expected_class, in_i.last_neuron, counted,
                   cnt_q[PW-1:0], votes};

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (in_i.last_neuron) begin
        cnt_d = '0;
      end else begin
        cnt_d = votes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pcv_fifo.sv
`default_nettype none

module pcv_fifo import pcv_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o,
  input  wire logic             pop_i
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PTR_W + 1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pcv_back.sv
`default_nettype none

module pcv_back import pcv_pkg::*; #(
  parameter int CLASS_SLOTS = CLASS_SLOTS_DEF,
  parameter int MAX_VOTES   = MAX_VOTES_DEF,
  parameter int VW          = $clog2(MAX_VOTES + 1),
  parameter int PW          = (MAX_VOTES > 1) ? $clog2(MAX_VOTES) : 1,
  parameter int EW          = 2 * LABEL_W + 2 + PW + VW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire logic [EW-1:0] q_data_i,
  output logic               q_pop_o,
  pcv_out_if.source          out_o
);

  // Only the labels that the input field can carry ever reach a slot.
  localparam int EFF_SLOTS = (CLASS_SLOTS < LABEL_SLOTS) ? CLASS_SLOTS : LABEL_SLOTS;
  localparam int SW        = $clog2(EFF_SLOTS);

  pcv_back_state_e state_q, state_d;

  logic [LABEL_W-1:0] hd_label, hd_expected;
  logic               hd_last, hd_counted;
  logic [PW-1:0]      hd_pos;
  logic [VW-1:0]      hd_votes;
  logic               hd_tally;

  logic [LABEL_W-1:0] cur_label_q, cur_expected_q;
  logic               cur_last_q;
  logic [PW-1:0]      cur_pos_q;
  logic [VW-1:0]      cur_votes_q;

  logic [VW+PW-1:0]   tally_mem [EFF_SLOTS];
  logic [VW+PW-1:0]   rd_q;
  logic [EFF_SLOTS-1:0] seen_q;

  logic [LABEL_W-1:0] leader_class_q;
  logic [VW-1:0]      leader_tally_q;
  logic [PW-1:0]      leader_fp_q;

  logic [LABEL_W-1:0] held_expected_q, held_class_q;
  logic [CONF_W-1:0]  held_conf_q;
  logic               out_valid_q;

  logic [VW:0]          rem_q, rem_sub;
  logic [CONF_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 div_ge;

  logic [SW-1:0] hd_idx, cur_idx;
  logic          seen_hit;
  logic [VW-1:0] old_tally, new_tally;
  logic [PW-1:0] new_fp;
  logic          take_lead;

  logic pop, upd_we, prep, div_step, commit_fire;

  assign {hd_label, hd_expected, hd_last, hd_counted, hd_pos, hd_votes} = q_data_i;
  assign hd_tally = hd_counted && (int'(hd_label) < EFF_SLOTS);
  assign hd_idx   = hd_label[SW-1:0];
  assign cur_idx  = cur_label_q[SW-1:0];

  assign seen_hit  = seen_q[cur_idx];
  assign old_tally = seen_hit ? rd_q[VW+PW-1:PW] : '0;
  assign new_fp    = seen_hit ? rd_q[PW-1:0] : cur_pos_q;
  assign new_tally = VW'(old_tally + 1'b1);
  // A tie goes to the class whose first vote came earlier.
  assign take_lead = (new_tally > leader_tally_q) ||
                     ((new_tally == leader_tally_q) && (new_fp < leader_fp_q));

  // Restoring division of leader_tally * 2^16 by the vote count, one bit a cycle.
  assign div_ge  = (rem_q >= {1'b0, cur_votes_q});
  assign rem_sub = div_ge ? (rem_q - {1'b0, cur_votes_q}) : rem_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BACK_IDLE: begin
        if (q_valid_i) begin
          if (hd_tally) begin
            state_d = BACK_UPDATE;
          end else if (hd_last) begin
            state_d = BACK_PREP;
          end
        end
      end
      BACK_UPDATE: begin
        state_d = cur_last_q ? BACK_PREP : BACK_IDLE;
      end
      BACK_PREP: begin
        state_d = BACK_DIVIDE;
      end
      BACK_DIVIDE: begin
        if (div_cnt_q == '0) begin
          state_d = BACK_COMMIT;
        end
      end
      BACK_COMMIT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = BACK_IDLE;
        end
      end
      default: begin
        state_d = BACK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    upd_we      = 1'b0;
    prep        = 1'b0;
    div_step    = 1'b0;
    commit_fire = 1'b0;
    case (state_q)
      BACK_IDLE:   pop = q_valid_i;
      BACK_UPDATE: upd_we = 1'b1;
      BACK_PREP:   prep = 1'b1;
      BACK_DIVIDE: div_step = 1'b1;
      BACK_COMMIT: commit_fire = !out_valid_q || out_o.ready;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign q_pop_o           = pop;
  assign out_o.valid       = out_valid_q;
  assign out_o.voted_class = held_class_q;
  assign out_o.confidence  = held_conf_q;

  always_ff @(posedge clk_i) begin
    if (pop && hd_tally) begin
      rd_q <= tally_mem[hd_idx];
    end
    if (upd_we) begin
      tally_mem[cur_idx] <= {new_tally, new_fp};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_label_q    <= hd_label;
      cur_expected_q <= hd_expected;
      cur_last_q     <= hd_last;
      cur_pos_q      <= hd_pos;
      cur_votes_q    <= hd_votes;
    end
    if (prep) begin
      rem_q     <= {1'b0, leader_tally_q};
      quo_q     <= '0;
      div_cnt_q <= DIV_CNT_W'(CONF_W - 1);
    end else if (div_step) begin
      rem_q     <= {rem_sub[VW-1:0], 1'b0};
      quo_q     <= {quo_q[CONF_W-2:0], div_ge};
      div_cnt_q <= DIV_CNT_W'(div_cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= BACK_IDLE;
      seen_q          <= '0;
      leader_class_q  <= '0;
      leader_tally_q  <= '0;
      leader_fp_q     <= '0;
      held_expected_q <= '0;
      held_class_q    <= '0;
      held_conf_q     <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_we) begin
        seen_q[cur_idx] <= 1'b1;
        if (take_lead) begin
          leader_class_q <= cur_label_q;
          leader_tally_q <= new_tally;
          leader_fp_q    <= new_fp;
        end
      end
      if (commit_fire) begin
        // A new expected class replaces the whole held answer.
        if (cur_expected_q != held_expected_q) begin
          held_expected_q <= cur_expected_q;
          held_class_q    <= leader_class_q;
          held_conf_q     <= quo_q;
        end else if (quo_q >= held_conf_q) begin
          held_class_q <= leader_class_q;
          held_conf_q  <= quo_q;
        end
        seen_q         <= '0;
        leader_class_q <= '0;
        leader_tally_q <= '0;
        leader_fp_q    <= '0;
        out_valid_q    <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/plurality_class_vote.sv
// Votes enter a four-deep queue at one request per cycle while it has room.
// Each tallied vote takes a tally memory read, then a write, in the back end;
// a vote past the vote limit or beyond the class slots is only popped from the queue.
// A last vote adds a setup step, bit-serial division and a commit step that waits
// while an earlier result has not been taken.
// Reset clears the queue, the seen bits, the leader and the held answer to zero.
`default_nettype none

module plurality_class_vote import pcv_pkg::*; #(
  parameter int CLASS_SLOTS = CLASS_SLOTS_DEF,
  parameter int MAX_VOTES   = MAX_VOTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pcv_in_if.sink    in_i,
  pcv_out_if.source out_o
);

  localparam int VW = $clog2(MAX_VOTES + 1);
  localparam int PW = (MAX_VOTES > 1) ? $clog2(MAX_VOTES) : 1;
  localparam int EW = 2 * LABEL_W + 2 + PW + VW;

  logic          push, full, q_valid, q_pop;
  logic [EW-1:0] push_data, q_data;

  pcv_front #(
    .MAX_VOTES (MAX_VOTES),
    .VW        (VW),
    .PW        (PW),
    .EW        (EW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .data_o (push_data),
    .full_i (full)
  );

  pcv_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  pcv_back #(
    .CLASS_SLOTS (CLASS_SLOTS),
    .MAX_VOTES   (MAX_VOTES),
    .VW          (VW),
    .PW          (PW),
    .EW          (EW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

FILE: tb/plurality_class_vote_test.sv
`timescale 1ns / 1ps

module plurality_class_vote_test;
  import pcv_pkg::*;

  localparam int SLOTS        = CLASS_SLOTS_DEF;
  localparam int VOTE_LIMIT   = MAX_VOTES_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;
  localparam int RANDOM_VOTES = 300;
  localparam logic [CONF_W-1:0] CONF_ONE = CONF_W'(1) << FRAC_W;

  typedef struct packed {
    logic [LABEL_W-1:0] neuron_class;
    logic [LABEL_W-1:0] expected_class;
    logic               last_neuron;
  } vote_t;

  typedef struct packed {
    logic [LABEL_W-1:0] voted_class;
    logic [CONF_W-1:0]  confidence;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcv_in_if  vote_bus ();
  pcv_out_if answer_bus ();

  plurality_class_vote #(
    .CLASS_SLOTS(SLOTS),
    .MAX_VOTES  (VOTE_LIMIT)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (vote_bus),
    .out_o (answer_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Vote counting state for the sample in progress.
  logic [10:0]        class_votes [SLOTS];
  logic [9:0]         class_first [SLOTS];
  logic               class_voted [SLOTS];
  logic [10:0]        votes_in_sample;
  logic [LABEL_W-1:0] lead_class;
  logic [10:0]        lead_count;
  logic [9:0]         lead_first;

  // Sticky answer kept across samples.
  logic [LABEL_W-1:0] held_expected;
  logic [LABEL_W-1:0] held_class;
  logic [CONF_W-1:0]  held_conf;

  answer_t pending_answers [$];

  int failures;
  int answers_checked;
  int votes_sent;
  int samples_closed;
  int cycle_count;
  int hold_off_cycles;
  int burst_left;
  bit gaps_on;

  function automatic void clear_counts();
    for (int i = 0; i < SLOTS; i++) begin
      class_votes[i] = '0;
      class_first[i] = '0;
      class_voted[i] = 1'b0;
    end
    votes_in_sample = '0;
    lead_class      = '0;
    lead_count      = '0;
    lead_first      = '0;
  endfunction

  function automatic void count_label(input logic [LABEL_W-1:0] label);
    logic [9:0] pos;
    pos = votes_in_sample[9:0];
    votes_in_sample = votes_in_sample + 11'd1;
    if (int'(label) >= SLOTS) return;
    if (!class_voted[label]) begin
      class_voted[label] = 1'b1;
      class_first[label] = pos;
      class_votes[label] = '0;
    end
    class_votes[label] = class_votes[label] + 11'd1;
    if (class_votes[label] > lead_count ||
        (class_votes[label] == lead_count && class_first[label] < lead_first)) begin
      lead_class = label;
      lead_count = class_votes[label];
      lead_first = class_first[label];
    end
  endfunction

  // Runs one accepted request through the vote and, on the last vote of a
  // sample, queues the sticky answer that the block must return.
  function automatic void tally_vote(input vote_t v);
    logic [27:0]       scaled;
    logic [CONF_W-1:0] conf;
    answer_t           ans;
    if (votes_in_sample < VOTE_LIMIT) count_label(v.neuron_class);
    if (!v.last_neuron) return;
    if (votes_in_sample == 0) begin
      conf = '0;
    end else begin
      scaled = {lead_count, {FRAC_W{1'b0}}} / votes_in_sample;
      conf = (scaled > CONF_ONE) ? CONF_ONE : scaled[CONF_W-1:0];
    end
    if (v.expected_class != held_expected) begin
      held_expected = v.expected_class;
      held_class    = lead_class;
      held_conf     = conf;
    end else if (conf >= held_conf) begin
      held_class = lead_class;
      held_conf  = conf;
    end
    ans.voted_class = held_class;
    ans.confidence  = held_conf;
    pending_answers.push_back(ans);
    samples_closed++;
    clear_counts();
  endfunction

  function automatic void report_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("%s", msg);
  endfunction

  // Offers one request, with random gaps between bursts when gaps are on.
  task automatic offer_vote(input vote_t v);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        vote_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    vote_bus.valid          <= 1'b1;
    vote_bus.neuron_class   <= v.neuron_class;
    vote_bus.expected_class <= v.expected_class;
    vote_bus.last_neuron    <= v.last_neuron;
    @(posedge clk_i);
    while (!vote_bus.ready) @(posedge clk_i);
    tally_vote(v);
    votes_sent++;
  endtask

  task automatic send_sample(input logic [LABEL_W-1:0] labels [$],
                             input logic [LABEL_W-1:0] expected);
    vote_t v;
    foreach (labels[i]) begin
      v.neuron_class   = labels[i];
      v.expected_class = expected;
      v.last_neuron    = (i == labels.size() - 1);
      offer_vote(v);
    end
  endtask

  task automatic wait_drained();
    vote_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_single_vote();
    send_sample('{6'd0}, 6'd0);
    send_sample('{6'd63}, 6'd63);
  endtask

  // Equal counts go to the class that was voted first.
  task automatic test_tie_break();
    send_sample('{6'd5, 6'd9, 6'd9, 6'd5}, 6'd10);
    send_sample('{6'd12, 6'd7, 6'd7, 6'd12, 6'd3}, 6'd10);
    send_sample('{6'd40, 6'd41, 6'd42}, 6'd10);
  endtask

  task automatic test_sticky_answer();
    send_sample('{6'd20, 6'd20}, 6'd10);
    send_sample('{6'd33}, 6'd10);
    send_sample('{6'd1, 6'd2}, 6'd0);
    send_sample('{6'd63, 6'd63, 6'd0}, 6'd63);
    send_sample('{6'd62, 6'd0, 6'd0}, 6'd63);
    send_sample('{6'd0, 6'd63}, 6'd63);
  endtask

  // One sample that runs one vote past the limit; the dropped last vote
  // still closes its sample.
  task automatic test_vote_limit();
    vote_t v;
    gaps_on = 1'b0;
    for (int i = 0; i <= VOTE_LIMIT; i++) begin
      v.neuron_class   = LABEL_W'($urandom_range(0, 3));
      v.expected_class = 6'd21;
      v.last_neuron    = (i == VOTE_LIMIT);
      offer_vote(v);
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // Output held off for a long stretch while single-vote samples keep coming,
  // so the input queue fills and the block pushes back.
  task automatic test_backpressure();
    vote_t v;
    hold_off_cycles = 400;
    gaps_on = 1'b0;
    for (int i = 0; i < 40; i++) begin
      v.neuron_class   = LABEL_W'($urandom);
      v.expected_class = LABEL_W'($urandom_range(0, 1));
      v.last_neuron    = 1'b1;
      offer_vote(v);
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_samples(input int count);
    logic [LABEL_W-1:0] expected;
    logic [LABEL_W-1:0] base;
    int target;
    int len;
    int spread;
    int roll;
    vote_t v;
    target   = votes_sent + count;
    expected = '0;
    while (votes_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) len = $urandom_range(1, 8);
      else if (roll < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      // Mostly keep the same expected class so the confidence compare matters.
      if ($urandom_range(0, 99) < 40) expected = LABEL_W'($urandom);
      spread  = $urandom_range(0, 1) ? 3 : 63;
      base    = LABEL_W'($urandom);
      gaps_on = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < len; i++) begin
        v.neuron_class   = base + LABEL_W'($urandom_range(0, spread));
        v.expected_class = expected;
        v.last_neuron    = (i == len - 1);
        offer_vote(v);
      end
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: switches among always ready, random stalls and a fixed
  // rotating pattern, with an optional long hold-off.
  initial begin
    int mode;
    int mode_left;
    logic [7:0] stall_pattern;
    answer_bus.ready <= 1'b0;
    mode          = 0;
    mode_left     = 0;
    stall_pattern = 8'b1011_0110;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        answer_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            answer_bus.ready <= 1'b1;
          end
          1: begin
            answer_bus.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            answer_bus.ready <= stall_pattern[0];
          end
          default: begin
            answer_bus.ready <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  answer_t got_answer;
  answer_t want_answer;

  always @(posedge clk_i) begin
    if (rst_ni && answer_bus.valid && answer_bus.ready) begin
      got_answer.voted_class = answer_bus.voted_class;
      got_answer.confidence  = answer_bus.confidence;
      if (pending_answers.size() == 0) begin
        report_failure($sformatf("unexpected result: class %0d confidence %0d",
                                 got_answer.voted_class, got_answer.confidence));
      end else begin
        want_answer = pending_answers.pop_front();
        answers_checked++;
        if (got_answer.voted_class !== want_answer.voted_class ||
            got_answer.confidence !== want_answer.confidence) begin
          report_failure($sformatf(
            "result %0d mismatch: expected class %0d confidence %0d, got class %0d confidence %0d",
            answers_checked, want_answer.voted_class, want_answer.confidence,
            got_answer.voted_class, got_answer.confidence));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_answers.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni                  <= 1'b0;
    vote_bus.valid          <= 1'b0;
    vote_bus.neuron_class   <= '0;
    vote_bus.expected_class <= '0;
    vote_bus.last_neuron    <= 1'b0;
    held_expected   = '0;
    held_class      = '0;
    held_conf       = '0;
    hold_off_cycles = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    clear_counts();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_vote();
    test_tie_break();
    test_sticky_answer();
    wait_drained();
    test_vote_limit();
    test_backpressure();
    test_random_samples(RANDOM_VOTES);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_answers.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_answers.size()));

    $display("Sent %0d votes in %0d samples, checked %0d results, %0d failures.",
             votes_sent, samples_closed, answers_checked, failures);
    $display("Covered ties, sticky updates, vote-limit samples and a long output stall.");
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
